[rtl/core/tsd_pkg.sv]
`timescale 1ns / 1ps
// shared types, reset values and helper functions for the scratchpad decoder
// no dependencies; imported by every module of the block

package tsd_pkg;

  // frame layout
  localparam int unsigned CountW    = 4;
  localparam int unsigned StoredLen = 5;
  localparam logic [CountW-1:0] LastIdx   = 4'd8;
  localparam logic [CountW-1:0] StoredLim = 4'd5;

  // crc
  localparam logic [7:0] CrcPoly = 8'h8C;

  // stored register reset values
  localparam logic [15:0] TempReset = 16'h0550;
  localparam logic [7:0]  HighReset = 8'h7F;
  localparam logic [7:0]  LowReset  = 8'h80;
  localparam logic [7:0]  ConfReset = 8'h7F;
  localparam logic        FineReset = 1'b1;

  // frame engine status towards the top level
  typedef struct packed {
    logic        last;
    logic        err;
    logic [15:0] temp;
    logic [7:0]  high;
    logic [7:0]  low;
    logic [7:0]  conf;
  } frame_res_t;

  // one byte of the reflected crc-8, shifting right
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // fraction nibble in sixteenths scaled to tenths: (k * 63) / 100
  function automatic logic [3:0] frac_tenths(input logic [3:0] k);
    logic [3:0] r;
    unique case (k)
      4'd0, 4'd1:   r = 4'd0;
      4'd2, 4'd3:   r = 4'd1;
      4'd4:         r = 4'd2;
      4'd5, 4'd6:   r = 4'd3;
      4'd7:         r = 4'd4;
      4'd8, 4'd9:   r = 4'd5;
      4'd10, 4'd11: r = 4'd6;
      4'd12:        r = 4'd7;
      4'd13, 4'd14: r = 4'd8;
      default:      r = 4'd9;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/tsd_if.sv]
`timescale 1ns / 1ps
// valid/ready channel interfaces for scratchpad bytes in and decoded results out
// no dependencies

interface tsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface tsd_out_if;
  logic               valid;
  logic               ready;
  logic               crc_error;
  logic [15:0]        raw_temperature;
  logic [7:0]         alarm_high;
  logic [7:0]         alarm_low;
  logic [7:0]         config_byte;
  logic signed [15:0] temp_tenths;
  logic signed [15:0] temp_whole;

  modport source (output valid, output crc_error, output raw_temperature,
                  output alarm_high, output alarm_low, output config_byte,
                  output temp_tenths, output temp_whole, input ready);
  modport sink   (input valid, input crc_error, input raw_temperature,
                  input alarm_high, input alarm_low, input config_byte,
                  input temp_tenths, input temp_whole, output ready);
endinterface

[rtl/core/tsd_frame.sv]
`timescale 1ns / 1ps
// frame engine: byte count, crc accumulator, captured bytes and stored registers
// depends on tsd_pkg

module tsd_frame (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic [7:0]          data_byte_i,
  input  logic                frame_start_i,
  output tsd_pkg::frame_res_t res_o
);
  import tsd_pkg::*;

  logic [CountW-1:0] count_q, count_d, cnt;
  logic [7:0]        crc_q, crc_d, crc_base, crc_new;
  logic [7:0]        bytes_q [StoredLen];
  logic [15:0]       temp_q, temp_d;
  logic [7:0]        high_q, high_d, low_q, low_d, conf_q, conf_d;
  logic              last, err;

  // restart on frame start, or after a full frame
  always_comb begin
    if (frame_start_i || (count_q > LastIdx)) begin
      cnt      = '0;
      crc_base = '0;
    end else begin
      cnt      = count_q;
      crc_base = crc_q;
    end
    crc_new = crc8_byte(crc_base, data_byte_i);
    last    = (cnt == LastIdx);
    err     = (crc_new != 8'h00);
  end

  // next state of count, crc and stored registers
  always_comb begin
    count_d = count_q;
    crc_d   = crc_q;
    temp_d  = temp_q;
    high_d  = high_q;
    low_d   = low_q;
    conf_d  = conf_q;
    if (adv_i) begin
      if (last) begin
        count_d = '0;
        crc_d   = '0;
        if (!err) begin
          temp_d = {bytes_q[1], bytes_q[0]};
          high_d = bytes_q[2];
          low_d  = bytes_q[3];
          conf_d = bytes_q[4];
        end
      end else begin
        count_d = cnt + 1'b1;
        crc_d   = crc_new;
      end
    end
  end

  // control and stored registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      crc_q   <= '0;
      temp_q  <= TempReset;
      high_q  <= HighReset;
      low_q   <= LowReset;
      conf_q  <= ConfReset;
    end else begin
      count_q <= count_d;
      crc_q   <= crc_d;
      temp_q  <= temp_d;
      high_q  <= high_d;
      low_q   <= low_d;
      conf_q  <= conf_d;
    end
  end

  // captured bytes zero to four, no reset
  always_ff @(posedge clk_i) begin
    if (adv_i && (cnt < StoredLim)) begin
      bytes_q[cnt[2:0]] <= data_byte_i;
    end
  end

  // status for the result register
  assign res_o.last = last;
  assign res_o.err  = err;
  assign res_o.temp = temp_d;
  assign res_o.high = high_d;
  assign res_o.low  = low_d;
  assign res_o.conf = conf_d;

  // checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= LastIdx)
    else $error("byte count beyond last byte");

  a_wrap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && last |=> count_q == '0 && crc_q == '0)
    else $error("count or crc not cleared after ninth byte");

  a_err_keeps_regs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && last && err |=> temp_q == $past(temp_q) && conf_q == $past(conf_q))
    else $error("stored registers changed on crc error");

endmodule

[rtl/core/tsd_convert.sv]
`timescale 1ns / 1ps
// converts the raw temperature word to tenths and rounded whole degrees
// depends on tsd_pkg

module tsd_convert (
  input  logic               fine_i,
  input  logic [15:0]        raw_i,
  output logic signed [15:0] tenths_o,
  output logic signed [15:0] whole_o
);
  import tsd_pkg::*;

  logic        neg;
  logic [15:0] mag, tenths_mag, whole_mag;
  logic [10:0] int_tenths;

  // sign-magnitude split; full-scale negative keeps its magnitude
  assign neg = raw_i[15];
  assign mag = neg ? (~raw_i + 16'd1) : raw_i;

  // integer part of bits ten to four times ten, plus the scaled fraction
  assign int_tenths = {4'd0, mag[10:4]} * 11'd10;

  always_comb begin
    if (fine_i) begin
      tenths_mag = {5'd0, int_tenths} + {12'd0, frac_tenths(mag[3:0])};
      whole_mag  = (mag >> 4) + {15'd0, mag[3]};
    end else begin
      tenths_mag = (mag << 2) + mag;
      whole_mag  = (mag >> 1) + {15'd0, mag[0]};
    end
  end

  // restore the sign, wrapping at 16 bits
  assign tenths_o = neg ? $signed(~tenths_mag + 16'd1) : $signed(tenths_mag);
  assign whole_o  = neg ? $signed(~whole_mag + 16'd1) : $signed(whole_mag);

endmodule

[rtl/core/temp_scratchpad_decoder.sv]
`timescale 1ns / 1ps
// top level of the scratchpad decoder: input register, frame engine, result register
// depends on tsd_pkg, tsd_if, tsd_frame and tsd_convert

// Takes one scratchpad byte per item and checks the reflected crc-8 over the
// nine bytes of a frame; frame_start forces the byte to be taken as byte zero,
// and after nine bytes the next one starts a new frame by itself. The ninth
// byte gives one result: on a zero residue the stored temperature, alarm and
// configuration registers are loaded from bytes zero to four, otherwise they
// are kept and crc_error is set. One item is accepted every cycle unless the
// input is stalled. A byte is held in the input register while the crc byte
// step runs on it, and the result of a ninth byte is loaded from there into
// the result register as that byte advances. The only stall is a ninth byte
// waiting in the input register while the previous result is still unread;
// it then moves on in the cycle that result is taken. Tenths and whole degrees
// are worked out from the held result and the fine_format setting (cfg_wdata_i,
// reset 1), which the user must write only while idle; not enforced by the block.

module temp_scratchpad_decoder (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  tsd_in_if.sink   in_i,
  tsd_out_if.source out_o
);
  import tsd_pkg::*;

  logic       fine_q;
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       start_q;
  logic       out_valid_q;
  logic       out_err_q;
  logic [15:0] out_temp_q;
  logic [7:0] out_high_q, out_low_q, out_conf_q;
  logic       out_free, adv, ld;
  frame_res_t res;

  // handshake: stage advances unless its result has nowhere to go
  assign out_free   = !out_valid_q || out_o.ready;
  assign adv        = in_valid_q && (!res.last || out_free);
  assign ld         = adv && res.last;
  assign in_i.ready = !in_valid_q || adv;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fine_q <= FineReset;
    end else if (cfg_we_i) begin
      fine_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q  <= in_i.data_byte;
      start_q <= in_i.frame_start;
    end
  end

  // frame engine
  tsd_frame u_frame (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .data_byte_i   (byte_q),
    .frame_start_i (start_q),
    .res_o         (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ld) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      out_err_q  <= res.err;
      out_temp_q <= res.temp;
      out_high_q <= res.high;
      out_low_q  <= res.low;
      out_conf_q <= res.conf;
    end
  end

  // degree conversion of the held result
  tsd_convert u_convert (
    .fine_i   (fine_q),
    .raw_i    (out_temp_q),
    .tenths_o (out_o.temp_tenths),
    .whole_o  (out_o.temp_whole)
  );

  assign out_o.valid           = out_valid_q;
  assign out_o.crc_error       = out_err_q;
  assign out_o.raw_temperature = out_temp_q;
  assign out_o.alarm_high      = out_high_q;
  assign out_o.alarm_low       = out_low_q;
  assign out_o.config_byte     = out_conf_q;

  // checks
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> in_valid_q && out_valid_q && res.last)
    else $error("input stalled without a blocked ninth byte");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld |-> !out_valid_q || out_o.ready)
    else $error("pending result overwritten");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld |=> out_valid_q && out_err_q == $past(res.err))
    else $error("result register not loaded from ninth byte");

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for temp_scratchpad_decoder: scratchpad bytes in, decoded readings out
// depends on tsd_pkg, tsd_if and the decoder rtl

module tb;
  import tsd_pkg::*;

  localparam int PhaseItems = 255;
  localparam int NumPhases  = 6;
  localparam int LongHold   = 60;
  localparam int Settle     = 4;
  localparam int DirRowsN   = 20;

  // one decoded reading, as the output channel carries it
  typedef struct packed {
    logic        err;
    logic [15:0] raw;
    logic [7:0]  high;
    logic [7:0]  low;
    logic [7:0]  conf;
    logic [15:0] tenths;
    logic [15:0] whole;
  } reading_t;

  // one row of the directed stimulus
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       crc_fill;
    logic       typed;
    reading_t   want;
  } dir_row_t;

  localparam reading_t NoReading    = '0;
  // error frame straight after reset: stored registers keep their reset values
  localparam reading_t ResetReading = '{1'b1, 16'h0550, 8'h7F, 8'h80, 8'h7F, 16'd850, 16'd85};

  localparam dir_row_t DirRows [DirRowsN] = '{
    // partial frame, dropped by the restart below
    '{8'h12, 1'b1, 1'b0, 1'b0, NoReading},
    '{8'h34, 1'b0, 1'b0, 1'b0, NoReading},
    // restart mid-frame: eight zeros and a bad check byte
    '{8'h00, 1'b1, 1'b0, 1'b0, NoReading},
    '{8'h00, 1'b0, 1'b0, 1'b0, NoReading},
    '{8'h00, 1'b0, 1'b0, 1'b0, NoReading},
    '{8'h00, 1'b0, 1'b0, 1'b0, NoReading},
    '{8'h00, 1'b0, 1'b0, 1'b0, NoReading},
    '{8'h00, 1'b0, 1'b0, 1'b0, NoReading},
    '{8'h00, 1'b0, 1'b0, 1'b0, NoReading},
    '{8'h00, 1'b0, 1'b0, 1'b0, NoReading},
    '{8'hFF, 1'b0, 1'b0, 1'b1, ResetReading},
    // next frame with no start flag, negative full-scale word, good check byte
    '{8'h00, 1'b0, 1'b0, 1'b0, NoReading},
    '{8'h80, 1'b0, 1'b0, 1'b0, NoReading},
    '{8'hFF, 1'b0, 1'b0, 1'b0, NoReading},
    '{8'h00, 1'b0, 1'b0, 1'b0, NoReading},
    '{8'hFF, 1'b0, 1'b0, 1'b0, NoReading},
    '{8'hAA, 1'b0, 1'b0, 1'b0, NoReading},
    '{8'h55, 1'b0, 1'b0, 1'b0, NoReading},
    '{8'h0F, 1'b0, 1'b0, 1'b0, NoReading},
    '{8'h00, 1'b0, 1'b1, 1'b0, NoReading}
  };

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic cfg_we_i    = 1'b0;
  logic cfg_wdata_i = 1'b0;

  tsd_in_if  in_if ();
  tsd_out_if out_if ();

  temp_scratchpad_decoder DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #1 clk_i = ~clk_i;

  // decoder state as predicted
  logic       fine_fmt;
  logic [7:0] pad_crc;
  int         pad_count;
  logic [7:0] pad_bytes [StoredLen];
  logic [15:0] temp_q;
  logic [7:0]  high_q;
  logic [7:0]  low_q;
  logic [7:0]  conf_q;

  reading_t pending_readings [$];
  int       fail_count     = 0;
  int       bytes_sent     = 0;
  int       frames_checked = 0;
  int       crc_errs       = 0;
  int       hold_requests  = 0;
  logic     calm           = 1'b0;

  // reflected crc-8, one bit at a time, lsb first
  function automatic logic [7:0] crc_next(input logic [7:0] acc, input logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ b[i];
      acc = acc >> 1;
      if (fb) acc = acc ^ CrcPoly;
    end
    return acc;
  endfunction

  function automatic void reset_model();
    fine_fmt  = FineReset;
    pad_crc   = '0;
    pad_count = 0;
    temp_q    = TempReset;
    high_q    = HighReset;
    low_q     = LowReset;
    conf_q    = ConfReset;
  endfunction

  // takes one accepted byte; on the ninth byte of a frame gives the reading
  function automatic void decode_byte(input logic [7:0] b, input logic s,
                                      output logic done, output reading_t r);
    logic        neg;
    logic [15:0] mag;
    logic [15:0] t;
    logic [15:0] w;
    int unsigned m32;
    int unsigned vt;
    int unsigned vw;
    if (s || pad_count > 8) begin
      pad_count = 0;
      pad_crc   = '0;
    end
    if (pad_count < StoredLen) pad_bytes[pad_count] = b;
    pad_crc   = crc_next(pad_crc, b);
    pad_count = pad_count + 1;
    done      = (pad_count == 9);
    r         = '0;
    if (done) begin
      r.err = (pad_crc != 8'h00);
      if (!r.err) begin
        temp_q = {pad_bytes[1], pad_bytes[0]};
        high_q = pad_bytes[2];
        low_q  = pad_bytes[3];
        conf_q = pad_bytes[4];
      end
      pad_count = 0;
      pad_crc   = '0;
      // sign-magnitude split; 0x8000 stays 0x8000
      neg = temp_q[15];
      mag = neg ? (~temp_q + 16'd1) : temp_q;
      m32 = mag;
      if (fine_fmt) begin
        vt = ((m32 & 32'h07F8) >> 4) * 10 + ((m32 & 32'h000F) * 63) / 100;
        vw = (m32 >> 4) + m32[3];
      end else begin
        vt = m32 * 5;
        vw = (m32 >> 1) + m32[0];
      end
      t = vt[15:0];
      w = vw[15:0];
      if (neg) begin
        t = ~t + 16'd1;
        w = ~w + 16'd1;
      end
      r.raw    = temp_q;
      r.high   = high_q;
      r.low    = low_q;
      r.conf   = conf_q;
      r.tenths = t;
      r.whole  = w;
    end
  endfunction

  // offer one item after an optional gap and wait for acceptance
  task automatic send_item(input logic [7:0] b, input logic s, input int gap,
                           input logic typed, input reading_t want);
    logic     done;
    reading_t r;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.data_byte   <= b;
    in_if.frame_start <= s;
    do @(posedge clk_i); while (!in_if.ready);
    bytes_sent++;
    decode_byte(b, s, done, r);
    if (done) pending_readings.push_back(typed ? want : r);
  endtask

  // stop offering and let every expected reading come out
  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic write_fine(input logic v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    fine_fmt = v;
  endtask

  function automatic logic [15:0] pick_temp();
    logic [15:0] w;
    case ($urandom_range(0, 7))
      0:       w = 16'h8000;
      1:       w = 16'h7FFF;
      2:       w = 16'hFFFF;
      3:       w = 16'h0000;
      4:       w = 16'($urandom_range(0, 16'h07FF));
      5:       w = 16'(-$urandom_range(0, 16'h0370));
      default: w = 16'($urandom);
    endcase
    return w;
  endfunction

  function automatic int pick_gap(input int gap_pct);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) return $urandom_range(1, 19);
    return 0;
  endfunction

  // one random chunk: mostly good frames, some corrupted, cut short or plain noise
  task automatic run_chunk(input int gap_pct);
    logic [7:0] fr [9];
    logic [15:0] w;
    logic [7:0] acc;
    int kind;
    int n;
    w     = pick_temp();
    fr[0] = w[7:0];
    fr[1] = w[15:8];
    for (int k = 2; k < 8; k++) fr[k] = 8'($urandom);
    acc = '0;
    for (int k = 0; k < 8; k++) acc = crc_next(acc, fr[k]);
    fr[8] = acc;
    kind  = $urandom_range(0, 99);
    n     = 9;
    if (kind >= 70 && kind < 82) fr[$urandom_range(0, 8)] ^= 8'(1 << $urandom_range(0, 7));
    else if (kind >= 82 && kind < 92) n = $urandom_range(1, 8);
    if (kind >= 92) begin
      n = $urandom_range(1, 12);
      for (int k = 0; k < n; k++)
        send_item(8'($urandom), ($urandom_range(0, 7) == 0), pick_gap(gap_pct), 1'b0, NoReading);
    end else begin
      for (int k = 0; k < n; k++)
        send_item(fr[k], (k == 0) && ($urandom_range(0, 3) != 0), pick_gap(gap_pct),
                  1'b0, NoReading);
    end
  endtask

  function automatic int pick_gap_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 6;
      default: return 35;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // compare every accepted reading with the oldest expectation
  always @(posedge clk_i) begin : result_check
    reading_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_readings.size() == 0) begin
        $error("reading out with nothing expected");
        fail_count++;
      end else begin
        want = pending_readings.pop_front();
        check_field("crc_error", 16'(want.err), 16'(out_if.crc_error));
        check_field("raw_temperature", want.raw, out_if.raw_temperature);
        check_field("alarm_high", 16'(want.high), 16'(out_if.alarm_high));
        check_field("alarm_low", 16'(want.low), 16'(out_if.alarm_low));
        check_field("config_byte", 16'(want.conf), 16'(out_if.config_byte));
        check_field("temp_tenths", want.tenths, out_if.temp_tenths);
        check_field("temp_whole", want.whole, out_if.temp_whole);
        frames_checked++;
        if (want.err) crc_errs++;
      end
    end
  end

  // receiver: random stall bursts, quiet stretches and the long hold-off on request
  initial begin : result_sink
    int stall_left;
    int mode_left;
    int stall_pct;
    int hold_served;
    stall_left  = 0;
    mode_left   = 0;
    stall_pct   = 0;
    hold_served = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode_left = $urandom_range(16, 128);
        stall_pct = pick_gap_pct();
      end
      mode_left--;
      if (hold_served != hold_requests) begin
        hold_served++;
        stall_left = LongHold;
      end
      if (stall_left == 0 && !calm && $urandom_range(0, 99) < stall_pct)
        stall_left = $urandom_range(1, 19);
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // main stimulus
  initial begin : stimulus
    int waited;
    in_if.valid       <= 1'b0;
    in_if.data_byte   <= '0;
    in_if.frame_start <= 1'b0;
    reset_model();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    for (int i = 0; i < DirRowsN; i++)
      send_item(DirRows[i].crc_fill ? pad_crc : DirRows[i].data, DirRows[i].start, 0,
                DirRows[i].typed, DirRows[i].want);

    // random phases, format alternating, last phase with no idling
    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      write_fine((ph % 2) != 0);
      if (ph == NumPhases - 1) calm <= 1'b1;
      if (ph == 2) begin
        // receiver holds off while bytes keep coming at full rate until the input stalls
        hold_requests <= hold_requests + 1;
        while (bytes_sent < DirRowsN + ph * PhaseItems + 80) run_chunk(0);
      end
      while (bytes_sent < DirRowsN + (ph + 1) * PhaseItems) begin
        run_chunk((ph == NumPhases - 1) ? 0 : pick_gap_pct());
        if (ph == 3 && bytes_sent >= DirRowsN + ph * PhaseItems + PhaseItems / 2
            && bytes_sent < DirRowsN + ph * PhaseItems + PhaseItems / 2 + 12)
          drain();
      end
    end

    // wait for the tail, with a limit
    in_if.valid <= 1'b0;
    waited = 0;
    while (pending_readings.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_readings.size() != 0) begin
      $error("%0d readings never came out", pending_readings.size());
      fail_count++;
    end
    repeat (8) @(posedge clk_i);

    $display("sent %0d bytes, checked %0d readings, %0d of them with crc errors",
             bytes_sent, frames_checked, crc_errs);
    $display("both sensor formats, restarts, stray bytes and output back-pressure exercised");
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // overall time limit
  initial begin : watchdog
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

[files.f]
rtl/core/tsd_pkg.sv
rtl/core/tsd_if.sv
rtl/core/tsd_frame.sv
rtl/core/tsd_convert.sv
rtl/core/temp_scratchpad_decoder.sv
sim/tb.sv
